/* hdl/spd_pkg.sv */
// Shared types and constants for the slotted page directory.
// No dependencies.
package spd_pkg;

    localparam int MAX_SLOTS        = 512;
    localparam int SLOT_W           = $clog2(MAX_SLOTS);
    localparam int CNT_W            = SLOT_W + 1;
    localparam int HEADER_BYTES     = 24;
    localparam int SLOT_ENTRY_BYTES = 8;

    localparam logic [3:0] OP_INIT     = 4'd0;
    localparam logic [3:0] OP_INSERT   = 4'd1;
    localparam logic [3:0] OP_MARK     = 4'd2;
    localparam logic [3:0] OP_UPDATE   = 4'd3;
    localparam logic [3:0] OP_APPLY    = 4'd4;
    localparam logic [3:0] OP_ROLLBACK = 4'd5;
    localparam logic [3:0] OP_GET      = 4'd6;
    localparam logic [3:0] OP_FIRST    = 4'd7;
    localparam logic [3:0] OP_NEXT     = 4'd8;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_NO_SPACE = 3'd1;
    localparam logic [2:0] ST_BEYOND   = 3'd2;
    localparam logic [2:0] ST_EMPTY    = 3'd3;
    localparam logic [2:0] ST_NOT_FOUND = 3'd4;

    typedef struct packed {
        logic [3:0]  opcode;
        logic [8:0]  slot;
        logic [12:0] tup_len;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [8:0]  slot_out;
        logic [12:0] offset;
        logic [12:0] length;
        logic [12:0] move_src;
        logic [12:0] move_dst;
        logic [12:0] move_len;
    } out_item_t;

    // one directory entry: offset and signed size
    typedef struct packed {
        logic [12:0]        offset;
        logic signed [13:0] size;
    } entry_t;

    // memory access request from the sequencer
    typedef struct packed {
        logic              rd_en;
        logic [SLOT_W-1:0] rd_addr;
        logic              wr_en;
        logic [SLOT_W-1:0] wr_addr;
        entry_t            wr_data;
    } mem_req_t;

endpackage

/* hdl/spd_dir_ram.sv */
// Slot directory storage: one write port, one registered read port.
// Depends on spd_pkg.
module spd_dir_ram
(
    input  logic              clk,
    input  spd_pkg::mem_req_t req,
    output spd_pkg::entry_t   rd_data
);

    spd_pkg::entry_t mem [spd_pkg::MAX_SLOTS];

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rd_data <= mem[req.rd_addr];
        end
    end

endmodule

/* hdl/spd_seq.sv */
// Operation sequencer: walks the directory one slot a cycle, read-modify-write for update and apply.
// Depends on spd_pkg.
module spd_seq
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [12:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  spd_pkg::in_item_t  in_item,
    output logic               out_valid,
    input  logic               out_stall,
    output spd_pkg::out_item_t out_item,
    output spd_pkg::mem_req_t  req,
    input  spd_pkg::entry_t    rd_data
);

    typedef enum logic [2:0] {
        S_IDLE, S_READ, S_EVAL, S_SCAN, S_DONE
    } state_t;

    localparam int SW = spd_pkg::SLOT_W;
    localparam int CW = spd_pkg::CNT_W;

    state_t               state_reg;
    logic [12:0]          page_reg;
    logic [12:0]          fp_reg;
    logic [CW-1:0]        count_reg;
    spd_pkg::in_item_t    op_reg;
    spd_pkg::out_item_t   res_reg;
    logic                 oval_reg;
    logic [CW-1:0]        idx_reg;      // slot being read this cycle
    logic                 rvalid_reg;   // rd_data belongs to slot idx_reg-1
    logic [CW-1:0]        ridx_reg;
    logic [13:0]          key_reg;      // offset bound for shifting
    logic signed [14:0]   delta_reg;
    logic signed [14:0]   fs_reg;       // free space snapshot

    logic [12:0] cfg_clamped;
    logic        can_accept;

    logic signed [14:0] fs_now;
    logic [2:0]         acc_status;
    spd_pkg::out_item_t res_start;

    logic               sz_pos;
    logic               scan_hit;
    spd_pkg::entry_t    mod_entry;
    logic               mod_we;
    logic [CW-1:0]      scan_end;

    logic               ev_we;
    spd_pkg::entry_t    ev_entry;
    logic signed [13:0] abs_sz;
    logic signed [14:0] need;
    logic [12:0]        span;

    always_comb
    begin
        if (cfg_data < 13'd64)
            cfg_clamped = 13'd64;
        else if (cfg_data > 13'd4096)
            cfg_clamped = 13'd4096;
        else
            cfg_clamped = cfg_data;
    end

    assign can_accept = (state_reg == S_IDLE) && !oval_reg;
    assign in_stall   = !can_accept;
    assign out_valid  = oval_reg;
    assign out_item   = res_reg;

    assign fs_now = $signed({2'b00, fp_reg}) - $signed(15'(spd_pkg::HEADER_BYTES))
                  - $signed(15'(count_reg * spd_pkg::SLOT_ENTRY_BYTES));

    // early status of an item decided at acceptance
    always_comb
    begin
        acc_status = spd_pkg::ST_OK;
        unique case (in_item.opcode)
            spd_pkg::OP_INSERT:
            begin
                if (in_item.tup_len == 13'd0
                    || fs_now < $signed({2'b00, in_item.tup_len}))
                    acc_status = spd_pkg::ST_NO_SPACE;
            end
            spd_pkg::OP_MARK, spd_pkg::OP_UPDATE, spd_pkg::OP_APPLY,
            spd_pkg::OP_ROLLBACK, spd_pkg::OP_GET:
            begin
                if ({1'b0, in_item.slot} >= count_reg)
                    acc_status = spd_pkg::ST_BEYOND;
            end
            default: acc_status = spd_pkg::ST_OK;
        endcase
        res_start        = '0;
        res_start.status = acc_status;
    end

    // per-entry logic for the directory walk
    always_comb
    begin
        sz_pos    = rd_data.size > 0;
        mod_entry = rd_data;
        mod_we    = 1'b0;
        scan_hit  = 1'b0;
        unique case (op_reg.opcode)
            spd_pkg::OP_INSERT: scan_hit = (rd_data.size == 14'sd0);
            spd_pkg::OP_UPDATE:
            begin
                if (sz_pos && {1'b0, rd_data.offset} < key_reg)
                begin
                    mod_we = 1'b1;
                    mod_entry.offset = 13'($signed({2'b00, rd_data.offset}) + delta_reg);
                end
            end
            spd_pkg::OP_APPLY:
            begin
                if (rd_data.size != 14'sd0 && {1'b0, rd_data.offset} < key_reg)
                begin
                    mod_we = 1'b1;
                    mod_entry.offset = 13'({2'b00, rd_data.offset} + delta_reg);
                end
            end
            default: scan_hit = sz_pos;
        endcase
    end

    assign scan_end = count_reg;

    // evaluation of the addressed entry (in the cycle after its read)
    assign abs_sz = rd_data.size < 0 ? -rd_data.size : rd_data.size;
    assign need   = $signed({2'b00, op_reg.tup_len}) - rd_data.size;

    always_comb
    begin
        ev_we    = 1'b0;
        ev_entry = rd_data;
        unique case (op_reg.opcode)
            spd_pkg::OP_MARK:
            begin
                ev_we = sz_pos;
                ev_entry.size = -rd_data.size;
            end
            spd_pkg::OP_ROLLBACK:
            begin
                ev_we = rd_data.size != 14'sd0;
                ev_entry.size = abs_sz;
            end
            spd_pkg::OP_UPDATE:
            begin
                ev_we = sz_pos && op_reg.tup_len != 13'd0 && !(fs_now < need);
                ev_entry.size = $signed({1'b0, op_reg.tup_len});
            end
            spd_pkg::OP_APPLY:
            begin
                ev_we    = rd_data.size != 14'sd0;
                ev_entry = '0;
            end
            default: ev_we = 1'b0;
        endcase
    end

    always_comb
    begin
        req         = '0;
        req.rd_addr = idx_reg[SW-1:0];
        req.rd_en   = (state_reg == S_READ) || (state_reg == S_SCAN);
        if (state_reg == S_SCAN && rvalid_reg && mod_we
            && (op_reg.opcode == spd_pkg::OP_UPDATE || op_reg.opcode == spd_pkg::OP_APPLY))
        begin
            req.wr_en   = 1'b1;
            req.wr_addr = ridx_reg[SW-1:0];
            req.wr_data = mod_entry;
        end
        else if (state_reg == S_EVAL && ev_we)
        begin
            req.wr_en   = 1'b1;
            req.wr_addr = op_reg.slot[SW-1:0];
            req.wr_data = ev_entry;
        end
    end

    assign span = rd_data.offset >= fp_reg ? rd_data.offset - fp_reg : 13'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            page_reg   <= 13'd4096;
            fp_reg     <= 13'd4096;
            count_reg  <= '0;
            op_reg     <= '0;
            res_reg    <= '0;
            oval_reg   <= 1'b0;
            rvalid_reg <= 1'b0;
            idx_reg    <= '0;
            ridx_reg   <= '0;
            key_reg    <= '0;
            delta_reg  <= '0;
            fs_reg     <= '0;
        end
        else
        begin
            if (cfg_we)
                page_reg <= cfg_clamped;
            if (oval_reg && !out_stall)
                oval_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    rvalid_reg <= 1'b0;
                    if (in_valid && can_accept)
                    begin
                        op_reg  <= in_item;
                        res_reg <= res_start;
                        fs_reg  <= fs_now;
                        unique case (in_item.opcode)
                            spd_pkg::OP_INIT:
                            begin
                                fp_reg    <= page_reg;
                                count_reg <= '0;
                                state_reg <= S_DONE;
                            end
                            spd_pkg::OP_INSERT:
                            begin
                                if (acc_status == spd_pkg::ST_NO_SPACE)
                                    state_reg <= S_DONE;
                                else
                                begin
                                    idx_reg   <= '0;
                                    state_reg <= S_SCAN;
                                end
                            end
                            spd_pkg::OP_MARK, spd_pkg::OP_UPDATE, spd_pkg::OP_APPLY,
                            spd_pkg::OP_ROLLBACK, spd_pkg::OP_GET:
                            begin
                                if (acc_status == spd_pkg::ST_BEYOND)
                                    state_reg <= S_DONE;
                                else
                                begin
                                    idx_reg   <= {1'b0, in_item.slot};
                                    state_reg <= S_READ;
                                end
                            end
                            spd_pkg::OP_FIRST:
                            begin
                                idx_reg   <= '0;
                                state_reg <= S_SCAN;
                            end
                            spd_pkg::OP_NEXT:
                            begin
                                idx_reg   <= {1'b0, in_item.slot} + 1'b1;
                                state_reg <= S_SCAN;
                            end
                            default: state_reg <= S_DONE;
                        endcase
                    end
                end
                S_READ: state_reg <= S_EVAL;
                S_EVAL:
                begin
                    // addressed entry is on rd_data
                    state_reg <= S_DONE;
                    if (rd_data.size == 14'sd0 || (rd_data.size < 0 &&
                        (op_reg.opcode == spd_pkg::OP_MARK || op_reg.opcode == spd_pkg::OP_UPDATE
                         || op_reg.opcode == spd_pkg::OP_GET)))
                        res_reg.status <= spd_pkg::ST_EMPTY;
                    else
                    begin
                        unique case (op_reg.opcode)
                            spd_pkg::OP_UPDATE:
                            begin
                                if (!ev_we)
                                    res_reg.status <= spd_pkg::ST_NO_SPACE;
                                else
                                begin
                                    res_reg.move_src <= fp_reg;
                                    res_reg.move_dst <= 13'($signed({2'b00, fp_reg}) - need);
                                    res_reg.move_len <= span;
                                    res_reg.length   <= op_reg.tup_len;
                                    // own offset shifts too (size now positive)
                                    res_reg.offset   <= 13'($signed({2'b00, rd_data.offset}) - need);
                                    fp_reg     <= 13'($signed({2'b00, fp_reg}) - need);
                                    key_reg    <= {1'b0, rd_data.offset} + rd_data.size[13:0];
                                    delta_reg  <= -need;
                                    idx_reg    <= '0;
                                    state_reg  <= S_SCAN;
                                end
                            end
                            spd_pkg::OP_APPLY:
                            begin
                                res_reg.move_src <= fp_reg;
                                res_reg.move_dst <= fp_reg + abs_sz[12:0];
                                res_reg.move_len <= span;
                                res_reg.offset   <= rd_data.offset;
                                res_reg.length   <= abs_sz[12:0];
                                fp_reg     <= fp_reg + abs_sz[12:0];
                                key_reg    <= {1'b0, rd_data.offset};
                                delta_reg  <= 15'(abs_sz);
                                idx_reg    <= '0;
                                state_reg  <= S_SCAN;
                            end
                            spd_pkg::OP_ROLLBACK:
                            begin
                                res_reg.offset <= rd_data.offset;
                                res_reg.length <= abs_sz[12:0];
                            end
                            default:
                            begin
                                res_reg.offset <= rd_data.offset;
                                res_reg.length <= rd_data.size[12:0];
                            end
                        endcase
                    end
                end
                S_SCAN:
                begin
                    // read slot idx_reg; rd_data holds slot ridx_reg
                    ridx_reg   <= idx_reg;
                    rvalid_reg <= idx_reg < scan_end;
                    idx_reg    <= idx_reg + 1'b1;
                    if (op_reg.opcode == spd_pkg::OP_UPDATE || op_reg.opcode == spd_pkg::OP_APPLY)
                    begin
                        if (!(idx_reg < scan_end) && !(rvalid_reg && ridx_reg + 1'b1 < scan_end))
                            state_reg <= S_DONE;
                    end
                    else if (rvalid_reg && scan_hit)
                    begin
                        state_reg <= S_DONE;
                        if (op_reg.opcode == spd_pkg::OP_INSERT)
                        begin
                            fp_reg <= fp_reg - op_reg.tup_len;
                            res_reg.slot_out <= ridx_reg[SW-1:0];
                            res_reg.offset   <= fp_reg - op_reg.tup_len;
                            res_reg.length   <= op_reg.tup_len;
                        end
                        else
                        begin
                            res_reg.slot_out <= ridx_reg[SW-1:0];
                            res_reg.offset   <= rd_data.offset;
                            res_reg.length   <= rd_data.size[12:0];
                        end
                    end
                    else if (!(idx_reg < scan_end) && !rvalid_reg)
                    begin
                        state_reg <= S_DONE;
                        if (op_reg.opcode == spd_pkg::OP_INSERT)
                        begin
                            if (count_reg >= CW'(spd_pkg::MAX_SLOTS)
                                || fs_reg < $signed({2'b00, op_reg.tup_len})
                                          + $signed(15'(spd_pkg::SLOT_ENTRY_BYTES)))
                                res_reg.status <= spd_pkg::ST_NO_SPACE;
                            else
                            begin
                                fp_reg    <= fp_reg - op_reg.tup_len;
                                count_reg <= count_reg + 1'b1;
                                res_reg.slot_out <= count_reg[SW-1:0];
                                res_reg.offset   <= fp_reg - op_reg.tup_len;
                                res_reg.length   <= op_reg.tup_len;
                            end
                        end
                        else
                            res_reg.status <= spd_pkg::ST_NOT_FOUND;
                    end
                end
                S_DONE:
                begin
                    oval_reg  <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

/* hdl/spd_ins_wr.sv */
// Insert write-back: stores the new directory entry after an insert completes.
// Depends on spd_pkg.
module spd_ins_wr
(
    input  spd_pkg::mem_req_t  seq_req,
    input  logic               out_valid,
    input  logic               out_valid_d,
    input  logic [3:0]         opcode,
    input  spd_pkg::out_item_t res,
    output spd_pkg::mem_req_t  req
);

    always_comb
    begin
        req = seq_req;
        // the sequencer never writes in the cycle the result first appears
        if (out_valid && !out_valid_d && opcode == spd_pkg::OP_INSERT
            && res.status == spd_pkg::ST_OK)
        begin
            req.wr_en        = 1'b1;
            req.wr_addr      = res.slot_out;
            req.wr_data.offset = res.offset;
            req.wr_data.size   = $signed({1'b0, res.length});
        end
    end

endmodule

/* hdl/slotted_page_directory.sv */
// Top level of the slotted page directory.
// Depends on spd_pkg, spd_seq, spd_ins_wr and spd_dir_ram.
//
// Usage:
//   in_valid/in_stall/in_item carry one operation item (opcode, slot,
//   tuple length). out_valid/out_stall/out_item return one result item per
//   operation. cfg_we/cfg_data write page_bytes (clamped to 64..4096); the
//   user must write only while idle; the block does not enforce it.
// Operation flow:
//   init and undefined opcodes go straight to the result; get, mark delete
//   and rollback read the addressed entry and evaluate it; insert, first
//   and next walk the directory one slot a cycle over the single read port;
//   update and apply delete read the addressed entry, then sweep every slot
//   read-modify-write. One item is worked on at a time.
// Reset:
//   free pointer and page size return to 4096, slot count to zero; directory
//   entries stay undefined until written, no clearing pass.
// Stall:
//   a held result keeps in_stall high; the next item waits until the result
//   is taken.
module slotted_page_directory
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [12:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  spd_pkg::in_item_t  in_item,
    output logic               out_valid,
    input  logic               out_stall,
    output spd_pkg::out_item_t out_item
);

    spd_pkg::mem_req_t seq_req;
    spd_pkg::mem_req_t ram_req;
    spd_pkg::entry_t   rd_data;
    logic              oval_d_reg;
    logic [3:0]        op_hold_reg;

    spd_seq u_seq
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item),
        .req       (seq_req),
        .rd_data   (rd_data)
    );

    // track the first cycle of each result and the opcode that made it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oval_d_reg  <= 1'b0;
            op_hold_reg <= spd_pkg::OP_INIT;
        end
        else
        begin
            oval_d_reg <= out_valid;
            if (in_valid && !in_stall)
                op_hold_reg <= in_item.opcode;
        end
    end

    spd_ins_wr u_ins_wr
    (
        .seq_req     (seq_req),
        .out_valid   (out_valid),
        .out_valid_d (oval_d_reg),
        .opcode      (op_hold_reg),
        .res         (out_item),
        .req         (ram_req)
    );

    spd_dir_ram u_ram
    (
        .clk     (clk),
        .req     (ram_req),
        .rd_data (rd_data)
    );

    // no new item while a result is held
    a_no_accept_while_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("item accepted while result pending");

    // a failed result carries no slot
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_item.status != spd_pkg::ST_OK) |-> out_item.slot_out == '0)
        else $error("failed result carries a slot");

    // result stays while stalled
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(out_item)))
        else $error("result dropped under stall");

endmodule

/* sim/tb_slotted_page_directory.sv */
`timescale 1ns / 100ps
// Testbench for slotted_page_directory: random and directed directory operations,
// with results checked against a behavioral page model. Depends on spd_pkg and the RTL.
module tb_slotted_page_directory;

    // Page model plus the queue of results it predicts. A slot entry is only
    // ever read below the slot count, so every entry read has been written.
    class page_scoreboard;
        int page_len = 4096;
        int free_ptr = 4096;
        int slot_cnt = 0;
        int offs[spd_pkg::MAX_SLOTS];
        int sizes[spd_pkg::MAX_SLOTS];
        spd_pkg::out_item_t expected_q[$];
        int mismatches = 0;
        int results_seen = 0;

        function void set_page(logic [12:0] v);
            int p;
            p = v;
            if (p < 64) p = 64;
            if (p > 4096) p = 4096;
            page_len = p;
        endfunction

        // Apply one accepted operation to the model and queue its result.
        function void note_item(spd_pkg::in_item_t it);
            spd_pkg::out_item_t r;
            int fs, sz, tsz, delta, off, i;
            r = '0;
            tsz = it.tup_len;
            unique case (it.opcode)
                spd_pkg::OP_INIT:
                begin
                    free_ptr = page_len;
                    slot_cnt = 0;
                end
                spd_pkg::OP_INSERT:
                begin
                    fs = free_ptr - spd_pkg::HEADER_BYTES
                       - slot_cnt * spd_pkg::SLOT_ENTRY_BYTES;
                    if (tsz == 0 || fs < tsz)
                        r.status = spd_pkg::ST_NO_SPACE;
                    else
                    begin
                        for (i = 0; i < slot_cnt; i++)
                            if (sizes[i] == 0) break;
                        if (i == slot_cnt && (slot_cnt >= spd_pkg::MAX_SLOTS
                            || fs < tsz + spd_pkg::SLOT_ENTRY_BYTES))
                            r.status = spd_pkg::ST_NO_SPACE;
                        else
                        begin
                            free_ptr = (free_ptr - tsz) & 8191;
                            offs[i] = free_ptr;
                            sizes[i] = tsz;
                            if (i == slot_cnt) slot_cnt++;
                            r.slot_out = 9'(i);
                            r.offset = 13'(free_ptr);
                            r.length = 13'(tsz);
                        end
                    end
                end
                spd_pkg::OP_MARK, spd_pkg::OP_UPDATE, spd_pkg::OP_APPLY,
                spd_pkg::OP_ROLLBACK, spd_pkg::OP_GET:
                begin
                    if (it.slot >= slot_cnt)
                        r.status = spd_pkg::ST_BEYOND;
                    else
                    begin
                        sz = sizes[it.slot];
                        off = offs[it.slot];
                        if (sz == 0 || (sz < 0 && (it.opcode == spd_pkg::OP_MARK ||
                            it.opcode == spd_pkg::OP_UPDATE || it.opcode == spd_pkg::OP_GET)))
                            r.status = spd_pkg::ST_EMPTY;
                        else if (it.opcode == spd_pkg::OP_MARK)
                        begin
                            sizes[it.slot] = -sz;
                            r.offset = 13'(off);
                            r.length = 13'(sz);
                        end
                        else if (it.opcode == spd_pkg::OP_GET)
                        begin
                            r.offset = 13'(off);
                            r.length = 13'(sz);
                        end
                        else if (it.opcode == spd_pkg::OP_ROLLBACK)
                        begin
                            if (sz < 0) sz = -sz;
                            sizes[it.slot] = sz;
                            r.offset = 13'(off);
                            r.length = 13'(sz);
                        end
                        else if (it.opcode == spd_pkg::OP_UPDATE)
                        begin
                            fs = free_ptr - spd_pkg::HEADER_BYTES
                               - slot_cnt * spd_pkg::SLOT_ENTRY_BYTES;
                            if (tsz == 0 || fs < tsz - sz)
                                r.status = spd_pkg::ST_NO_SPACE;
                            else
                            begin
                                delta = sz - tsz;
                                r.move_src = 13'(free_ptr);
                                r.move_dst = 13'((free_ptr + delta) & 8191);
                                r.move_len = 13'((off >= free_ptr) ? off - free_ptr : 0);
                                free_ptr = (free_ptr + delta) & 8191;
                                sizes[it.slot] = tsz;
                                // shift live tuples that sit below the old end
                                for (i = 0; i < slot_cnt; i++)
                                    if (sizes[i] > 0 && offs[i] < off + sz)
                                        offs[i] = (offs[i] + delta) & 8191;
                                r.offset = 13'(offs[it.slot]);
                                r.length = 13'(tsz);
                            end
                        end
                        else
                        begin
                            if (sz < 0) sz = -sz;
                            r.move_src = 13'(free_ptr);
                            r.move_dst = 13'((free_ptr + sz) & 8191);
                            r.move_len = 13'((off >= free_ptr) ? off - free_ptr : 0);
                            free_ptr = (free_ptr + sz) & 8191;
                            sizes[it.slot] = 0;
                            offs[it.slot] = 0;
                            for (i = 0; i < slot_cnt; i++)
                                if (sizes[i] != 0 && offs[i] < off)
                                    offs[i] = (offs[i] + sz) & 8191;
                            r.offset = 13'(off);
                            r.length = 13'(sz);
                        end
                    end
                end
                spd_pkg::OP_FIRST, spd_pkg::OP_NEXT:
                begin
                    r.status = spd_pkg::ST_NOT_FOUND;
                    for (i = (it.opcode == spd_pkg::OP_FIRST) ? 0 : it.slot + 1;
                         i < slot_cnt; i++)
                        if (sizes[i] > 0)
                        begin
                            r.status = spd_pkg::ST_OK;
                            r.slot_out = 9'(i);
                            r.offset = 13'(offs[i]);
                            r.length = 13'(sizes[i]);
                            break;
                        end
                end
                default: ;
            endcase
            expected_q.push_back(r);
        endfunction

        // Compare one result with the oldest prediction.
        function void check_result(spd_pkg::out_item_t got);
            spd_pkg::out_item_t exp;
            results_seen++;
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %p", got);
                return;
            end
            exp = expected_q.pop_front();
            if (got.status !== exp.status || got.slot_out !== exp.slot_out ||
                got.offset !== exp.offset || got.length !== exp.length ||
                got.move_src !== exp.move_src || got.move_dst !== exp.move_dst ||
                got.move_len !== exp.move_len)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch at %0t: expected %p actual %p", $realtime, exp, got);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [12:0] cfg_data;
    logic in_valid;
    logic in_stall;
    spd_pkg::in_item_t in_item;
    logic out_valid;
    logic out_stall;
    spd_pkg::out_item_t out_item;

    page_scoreboard sb;
    bit calm;           // no idling on either side while set
    int items_sent;
    int page_writes;

    slotted_page_directory u_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Note accepted items and check results; values read here are the
    // pre-edge ones since everything else updates with nonblocking writes.
    // Hold back results at random, except in the calm stretch.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                sb.note_item(in_item);
            if (out_valid && !out_stall)
                sb.check_result(out_item);
            out_stall <= !calm && ($urandom_range(99) < 31);
        end
    end

    // Offer one item and hold it until the block takes it. Stall is stable
    // at the falling edge, so sampling there decides the next rising edge.
    task automatic send_item(logic [3:0] op, logic [8:0] slot, logic [12:0] size);
        spd_pkg::in_item_t it;
        it.opcode = op;
        it.slot = slot;
        it.tup_len = size;
        if (!calm && $urandom_range(99) < 31)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item <= it;
        @(negedge clk);
        while (in_stall) @(negedge clk);
        @(posedge clk);
        items_sent++;
    endtask

    // Drain outstanding results, then write the page size while idle.
    task automatic write_page(logic [12:0] v);
        in_valid <= 1'b0;
        @(negedge clk);
        while (sb.expected_q.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.set_page(v);
        page_writes++;
    endtask

    // Weighted random operation; slots mostly near the live directory.
    task automatic send_random();
        int pick;
        logic [3:0] op;
        logic [8:0] slot;
        logic [12:0] size;
        pick = $urandom_range(99);
        if (pick < 2) op = spd_pkg::OP_INIT;
        else if (pick < 32) op = spd_pkg::OP_INSERT;
        else if (pick < 42) op = spd_pkg::OP_MARK;
        else if (pick < 54) op = spd_pkg::OP_UPDATE;
        else if (pick < 64) op = spd_pkg::OP_APPLY;
        else if (pick < 71) op = spd_pkg::OP_ROLLBACK;
        else if (pick < 80) op = spd_pkg::OP_GET;
        else if (pick < 86) op = spd_pkg::OP_FIRST;
        else if (pick < 97) op = spd_pkg::OP_NEXT;
        else op = 4'($urandom_range(9, 15));
        if ($urandom_range(99) < 85) slot = 9'($urandom_range(0, sb.slot_cnt));
        else slot = 9'($urandom_range(0, 511));
        pick = $urandom_range(99);
        if (pick < 80) size = 13'($urandom_range(1, 48));
        else if (pick < 90) size = 13'($urandom_range(1, 600));
        else size = 13'($urandom_range(0, 8191));
        send_item(op, slot, size);
    endtask

    initial
    begin
        int n;
        int guard;
        sb = new();
        calm = 1'b0;
        items_sent = 0;
        page_writes = 0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_data = '0;
        in_valid = 1'b0;
        in_item = '0;
        out_stall = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: boundaries, every operation and each corner case.
        send_item(spd_pkg::OP_FIRST, 9'd0, 13'd0);          // empty page
        send_item(spd_pkg::OP_GET, 9'd0, 13'd5);            // slot beyond count
        send_item(spd_pkg::OP_INSERT, 9'd0, 13'd0);         // zero size
        send_item(spd_pkg::OP_INSERT, 9'd0, 13'd8191);      // too big
        send_item(spd_pkg::OP_INSERT, 9'd0, 13'd100);
        send_item(spd_pkg::OP_INSERT, 9'd0, 13'd1);
        send_item(spd_pkg::OP_INSERT, 9'd0, 13'd40);
        send_item(spd_pkg::OP_MARK, 9'd1, 13'd0);
        send_item(spd_pkg::OP_GET, 9'd1, 13'd0);            // deleted slot
        send_item(spd_pkg::OP_UPDATE, 9'd1, 13'd7);         // deleted slot
        send_item(spd_pkg::OP_ROLLBACK, 9'd1, 13'd0);
        send_item(spd_pkg::OP_ROLLBACK, 9'd0, 13'd0);       // live tuple
        send_item(spd_pkg::OP_UPDATE, 9'd0, 13'd150);       // grow
        send_item(spd_pkg::OP_UPDATE, 9'd2, 13'd3);         // shrink
        send_item(spd_pkg::OP_UPDATE, 9'd2, 13'd0);         // zero size
        send_item(spd_pkg::OP_MARK, 9'd0, 13'd0);
        send_item(spd_pkg::OP_APPLY, 9'd0, 13'd0);
        send_item(spd_pkg::OP_APPLY, 9'd0, 13'd0);          // already empty
        send_item(spd_pkg::OP_NEXT, 9'd0, 13'd0);
        send_item(spd_pkg::OP_NEXT, 9'd511, 13'd0);
        send_item(spd_pkg::OP_INSERT, 9'd0, 13'd20);        // reuses the empty slot
        send_item(4'd15, 9'd511, 13'd8191);                 // undefined opcode
        send_item(4'd9, 9'd0, 13'd0);
        send_item(spd_pkg::OP_INIT, 9'd0, 13'd0);

        // Random phases, each begun by a page size write and an init.
        for (n = 0; n < 800; n++)
        begin
            case (n)
                0: write_page(13'd64);
                160: write_page(13'd8191);     // clamps to the top
                320: write_page(13'd0);        // clamps to the bottom
                480: write_page(13'd4096);
                640: write_page(13'($urandom_range(64, 4096)));
                default: ;
            endcase
            if (n % 160 == 0) send_item(spd_pkg::OP_INIT, 9'd0, 13'd0);
            calm = (n >= 300 && n < 420);
            send_random();
        end
        in_valid <= 1'b0;
        calm = 1'b0;

        @(negedge clk);
        guard = 0;
        while (sb.expected_q.size() != 0 && guard < 200000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (600) @(posedge clk);

        $display("Ran %0d operations under %0d page sizes; %0d results checked.",
                 items_sent, page_writes, sb.results_seen);
        if (sb.mismatches == 0 && sb.expected_q.size() == 0)
            $display("ALL CHECKS PASSED");
        else
        begin
            $display("%0d mismatches, %0d results missing", sb.mismatches,
                     sb.expected_q.size());
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial
    begin
        #20000000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

/* files.f */
hdl/spd_pkg.sv
hdl/spd_dir_ram.sv
hdl/spd_seq.sv
hdl/spd_ins_wr.sv
hdl/slotted_page_directory.sv
sim/tb_slotted_page_directory.sv
